### design/obmv_pkg.sv
// Shared constants and types for the OHLC bar merger.
package obmv_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_GROUP_DEF   = 256;
  localparam int unsigned PRICE_BITS_DEF  = 24;
  localparam int unsigned VOLUME_BITS_DEF = 24;

  // Fixed widths of the running sums and pass-through fields
  localparam int unsigned COST_W = 56;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned CNT_W  = 9;

  // Register port
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_GROUP_SIZE = '0;
  localparam logic [CNT_W-1:0]     GROUP_SIZE_RST = CNT_W'(1);

  // Sequencer commands to the accumulator
  typedef struct packed {
    logic capture;  // latch an accepted bar and its volume*close product
    logic accum;    // fold the latched bar into the running group
    logic clear;    // start a new group
  } acc_ctl_t;

endpackage

### design/ohlc_bar_merge_vwap.sv
// Top level of the OHLC bar merger: register port, sequencer and result register.
//
// Merges each run of group_size price bars into one bar: first open and time
// tag, highest high, lowest low, summed volume (saturating, Q20.12) and the
// volume-weighted close sum(volume*close)/sum(volume), truncated and clipped
// to the largest price. A bar with end_of_data set closes a partial group.
// Zero total volume gives close 0 with zero_volume set. group_size (address
// 0) reads back; 0 acts as 1 and values above MAX_GROUP act as MAX_GROUP.
// One bar at a time goes through the block: a bar that does not close its
// group is latched with its multiply, then accumulated. A closing bar then
// starts the divider, runs through the restoring divider (one quotient bit
// per cycle; it finishes without stepping when the close saturates, and it
// is not started when the volume is zero) and loads the result register.
// The load waits while the result register still holds an untaken bar. The
// result register holds a finished bar until it is taken while the next bars
// are already going in.
module ohlc_bar_merge_vwap
  import obmv_pkg::*;
#(
  parameter int unsigned MAX_GROUP   = MAX_GROUP_DEF,
  parameter int unsigned PRICE_BITS  = PRICE_BITS_DEF,
  parameter int unsigned VOLUME_BITS = VOLUME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  // bar input
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [PRICE_BITS-1:0]  open_price_i,
  input  logic [PRICE_BITS-1:0]  high_price_i,
  input  logic [PRICE_BITS-1:0]  low_price_i,
  input  logic [PRICE_BITS-1:0]  close_price_i,
  input  logic [VOLUME_BITS-1:0] bar_volume_in_i,
  input  logic [TAG_W-1:0]       time_tag_i,
  input  logic                   end_of_data_i,
  // merged bar output
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [PRICE_BITS-1:0]  merged_open_o,
  output logic [PRICE_BITS-1:0]  merged_high_o,
  output logic [PRICE_BITS-1:0]  merged_low_o,
  output logic [PRICE_BITS-1:0]  merged_close_o,
  output logic [SUM_W-1:0]       merged_volume_o,
  output logic [TAG_W-1:0]       merged_tag_o,
  output logic [CNT_W-1:0]       bars_merged_o,
  output logic                   zero_volume_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;

  // ---- register port ----
  logic [CNT_W-1:0]     group_size_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_GROUP_SIZE);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_GROUP_SIZE) ? APB_DW'(group_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GROUP_SIZE_RST;
    end else if (cfg_wr) begin
      group_size_q <= pwdata[CNT_W-1:0];
    end
  end

  // effective group size: zero means one, clipped at MAX_GROUP
  logic [31:0] eff_size;
  assign eff_size = (group_size_q == '0) ? 32'd1 :
                    ((32'(group_size_q) > 32'(MAX_GROUP)) ? 32'(MAX_GROUP)
                                                          : 32'(group_size_q));

  // ---- accumulator ----
  acc_ctl_t              acc_ctl;
  logic [PRICE_BITS-1:0] first_open, run_high, run_low;
  logic [SUM_W-1:0]      vol_sum;
  logic [COST_W-1:0]     cost_sum;
  logic [TAG_W-1:0]      first_tag;
  logic [CNT_W-1:0]      cnt, cnt_inc;
  logic                  in_fire, out_free, last_q, group_done;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;

  assign acc_ctl.capture = in_fire;
  assign acc_ctl.accum   = (state_q == ST_ACC);
  assign acc_ctl.clear   = (state_q == ST_DONE) && out_free;

  // count wraps to zero only in the 9-bit rollover case, which also closes
  assign group_done = last_q || (cnt_inc == '0) || (32'(cnt_inc) >= eff_size);

  obmv_acc #(
    .PRICE_BITS  (PRICE_BITS),
    .VOLUME_BITS (VOLUME_BITS)
  ) u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (acc_ctl),
    .open_i       (open_price_i),
    .high_i       (high_price_i),
    .low_i        (low_price_i),
    .close_i      (close_price_i),
    .volume_i     (bar_volume_in_i),
    .tag_i        (time_tag_i),
    .first_open_o (first_open),
    .run_high_o   (run_high),
    .run_low_o    (run_low),
    .vol_sum_o    (vol_sum),
    .cost_sum_o   (cost_sum),
    .first_tag_o  (first_tag),
    .cnt_o        (cnt),
    .cnt_inc_o    (cnt_inc)
  );

  // ---- divider ----
  logic                  div_start, div_busy, zero_vol;
  logic [PRICE_BITS-1:0] quot;

  assign zero_vol  = (vol_sum == '0);
  assign div_start = (state_q == ST_START) && !zero_vol;

  obmv_div #(
    .PRICE_BITS (PRICE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cost_sum),
    .divisor_i  (vol_sum),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // ---- sequencer and result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      last_q          <= 1'b0;
      out_valid_o     <= 1'b0;
      merged_open_o   <= '0;
      merged_high_o   <= '0;
      merged_low_o    <= '0;
      merged_close_o  <= '0;
      merged_volume_o <= '0;
      merged_tag_o    <= '0;
      bars_merged_o   <= '0;
      zero_volume_o   <= 1'b0;
    end else begin
      // a taken item is replaced in ST_DONE, so only clear outside it
      if (out_valid_o && out_ready_i && (state_q != ST_DONE)) out_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            last_q  <= end_of_data_i;
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          state_q <= group_done ? ST_START : ST_IDLE;
        end
        ST_START: begin
          state_q <= zero_vol ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          if (!div_busy) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_o     <= 1'b1;
            merged_open_o   <= first_open;
            merged_high_o   <= run_high;
            merged_low_o    <= run_low;
            merged_close_o  <= zero_vol ? '0 : quot;
            merged_volume_o <= vol_sum;
            merged_tag_o    <= first_tag;
            bars_merged_o   <= cnt;
            zero_volume_o   <= zero_vol;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/obmv_acc.sv
// Group accumulator: bar latch, volume*close multiplier and running OHLC sums.
module obmv_acc
  import obmv_pkg::*;
#(
  parameter int unsigned PRICE_BITS  = PRICE_BITS_DEF,
  parameter int unsigned VOLUME_BITS = VOLUME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  acc_ctl_t               ctl_i,
  input  logic [PRICE_BITS-1:0]  open_i,
  input  logic [PRICE_BITS-1:0]  high_i,
  input  logic [PRICE_BITS-1:0]  low_i,
  input  logic [PRICE_BITS-1:0]  close_i,
  input  logic [VOLUME_BITS-1:0] volume_i,
  input  logic [TAG_W-1:0]       tag_i,
  output logic [PRICE_BITS-1:0]  first_open_o,
  output logic [PRICE_BITS-1:0]  run_high_o,
  output logic [PRICE_BITS-1:0]  run_low_o,
  output logic [SUM_W-1:0]       vol_sum_o,
  output logic [COST_W-1:0]      cost_sum_o,
  output logic [TAG_W-1:0]       first_tag_o,
  output logic [CNT_W-1:0]       cnt_o,
  output logic [CNT_W-1:0]       cnt_inc_o
);

  localparam int unsigned PROD_W = PRICE_BITS + VOLUME_BITS;
  localparam int unsigned SUMC_W = ((PROD_W > COST_W) ? PROD_W : COST_W) + 1;
  localparam logic [SUMC_W-1:0] COST_LIM = SUMC_W'({COST_W{1'b1}});

  // latched bar
  logic [PRICE_BITS-1:0]  bar_open_q, bar_high_q, bar_low_q;
  logic [VOLUME_BITS-1:0] bar_vol_q;
  logic [TAG_W-1:0]       bar_tag_q;
  logic [PROD_W-1:0]      prod_q;

  // group state
  logic [PRICE_BITS-1:0] first_open_q, run_high_q, run_low_q;
  logic [SUM_W-1:0]      vol_sum_q;
  logic [COST_W-1:0]     cost_sum_q;
  logic [TAG_W-1:0]      first_tag_q;
  logic [CNT_W-1:0]      cnt_q;

  logic [SUM_W:0]        vol_add;
  logic [SUMC_W-1:0]     cost_add;
  logic [SUM_W-1:0]      vol_sum_d;
  logic [COST_W-1:0]     cost_sum_d;

  assign vol_add    = (SUM_W+1)'(vol_sum_q) + (SUM_W+1)'(bar_vol_q);
  assign vol_sum_d  = vol_add[SUM_W] ? {SUM_W{1'b1}} : vol_add[SUM_W-1:0];
  assign cost_add   = SUMC_W'(cost_sum_q) + SUMC_W'(prod_q);
  assign cost_sum_d = (cost_add > COST_LIM) ? {COST_W{1'b1}} : cost_add[COST_W-1:0];
  assign cnt_inc_o  = cnt_q + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      bar_open_q <= open_i;
      bar_high_q <= high_i;
      bar_low_q  <= low_i;
      bar_vol_q  <= volume_i;
      bar_tag_q  <= tag_i;
      prod_q     <= PROD_W'(volume_i) * PROD_W'(close_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_open_q <= '0;
      run_high_q   <= '0;
      run_low_q    <= '1;
      vol_sum_q    <= '0;
      cost_sum_q   <= '0;
      first_tag_q  <= '0;
      cnt_q        <= '0;
    end else if (ctl_i.clear) begin
      first_open_q <= '0;
      run_high_q   <= '0;
      run_low_q    <= '1;
      vol_sum_q    <= '0;
      cost_sum_q   <= '0;
      first_tag_q  <= '0;
      cnt_q        <= '0;
    end else if (ctl_i.accum) begin
      if (cnt_q == '0) begin
        first_open_q <= bar_open_q;
        first_tag_q  <= bar_tag_q;
        run_high_q   <= bar_high_q;
        run_low_q    <= bar_low_q;
      end else begin
        if (bar_high_q > run_high_q) run_high_q <= bar_high_q;
        if (bar_low_q < run_low_q)   run_low_q  <= bar_low_q;
      end
      vol_sum_q  <= vol_sum_d;
      cost_sum_q <= cost_sum_d;
      cnt_q      <= cnt_inc_o;
    end
  end

  assign first_open_o = first_open_q;
  assign run_high_o   = run_high_q;
  assign run_low_o    = run_low_q;
  assign vol_sum_o    = vol_sum_q;
  assign cost_sum_o   = cost_sum_q;
  assign first_tag_o  = first_tag_q;
  assign cnt_o        = cnt_q;

endmodule

### design/obmv_div.sv
// Restoring divider, one quotient bit per cycle, saturating at the price range.
module obmv_div
  import obmv_pkg::*;
#(
  parameter int unsigned PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COST_W-1:0]     dividend_i,
  input  logic [SUM_W-1:0]      divisor_i,
  output logic                  busy_o,
  output logic [PRICE_BITS-1:0] quot_o
);

  localparam int unsigned HI_W   = COST_W - PRICE_BITS;
  localparam int unsigned CMP_W  = (HI_W > SUM_W) ? HI_W : SUM_W;
  localparam int unsigned STEP_W = $clog2(PRICE_BITS + 1);

  logic [SUM_W-1:0]      rem_q, div_q;
  logic [PRICE_BITS-1:0] quo_q;
  logic [STEP_W-1:0]     step_q;
  logic                  busy_q;

  logic [CMP_W-1:0] hi_ext, div_ext;
  logic             ovf;
  logic [SUM_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign hi_ext  = CMP_W'(dividend_i[COST_W-1:PRICE_BITS]);
  assign div_ext = CMP_W'(divisor_i);
  assign ovf     = (hi_ext >= div_ext);   // quotient would not fit the price width

  assign rem_sh  = {rem_q, quo_q[PRICE_BITS-1]};
  assign ge      = (rem_sh >= {1'b0, div_q});
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= !ovf;
      step_q <= STEP_W'(PRICE_BITS);
    end else if (busy_q) begin
      busy_q <= (step_q != STEP_W'(1));
      step_q <= step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= hi_ext[SUM_W-1:0];
      quo_q <= ovf ? {PRICE_BITS{1'b1}} : dividend_i[PRICE_BITS-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
      quo_q <= {quo_q[PRICE_BITS-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule
